FILE: design/fat12_cluster_table_engine_top_defines.svh
// ----------------------------------------------------------------------------
// FAT12 cluster table engine: assertion macros
// Shared helpers for the concurrent checks of the engine.
// ----------------------------------------------------------------------------
`ifndef FAT12_CLUSTER_TABLE_ENGINE_TOP_DEFINES_SVH
`define FAT12_CLUSTER_TABLE_ENGINE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FAT12_ASSERT_HOLDS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FAT12_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/fat12_pkg.sv
// ----------------------------------------------------------------------------
// FAT12 cluster table engine package
// Widths, codes, reset values and types shared by the engine's modules.
// ----------------------------------------------------------------------------
package fat12_pkg;

   localparam int MAX_ENTRIES_DEFAULT = 4096;
   localparam int LANES               = 3;
   localparam int LANE_W              = $clog2(LANES);
   localparam int BYTE_W              = 8;
   localparam int ENTRY_W             = 12;
   localparam int COUNT_W             = 12;
   localparam int ADDR_W              = 13;
   localparam int BYTES_W             = 24;
   localparam int CFG_BYTES_W         = 13;
   localparam int OP_W                = 3;
   localparam int DEFAULT_ROWS        = (MAX_ENTRIES_DEFAULT + 1) / 2;
   localparam int REQ_DATA_W          = 48;
   localparam int RSP_DATA_W          = 72;

   localparam logic [COUNT_W-1:0]     CLUSTER_COUNT_RESET = 12'd713;
   localparam logic [CFG_BYTES_W-1:0] CLUSTER_BYTES_RESET = 13'd1024;
   localparam logic [BYTES_W-1:0]     BYTES_MAX           = 24'hFF_FFFF;

   // Division by three: floor(a * 2731 / 8192) is exact for every 13-bit a.
   localparam logic [ENTRY_W-1:0] RECIP3       = 12'd2731;
   localparam int                 RECIP3_SHIFT = 13;

   localparam logic [BYTE_W-1:0] LOW_NIBBLE  = 8'h0F;
   localparam logic [BYTE_W-1:0] HIGH_NIBBLE = 8'hF0;

   typedef enum logic [OP_W-1:0] {
      OP_READ_BYTE   = 3'd0,
      OP_WRITE_BYTE  = 3'd1,
      OP_READ_ENTRY  = 3'd2,
      OP_WRITE_ENTRY = 3'd3,
      OP_CLEAR_ENTRY = 3'd4,
      OP_FIRST_FREE  = 3'd5,
      OP_SECOND_FREE = 3'd6,
      OP_COUNT_FREE  = 3'd7
   } op_type;

   typedef enum logic {
      CSR_CLUSTER_COUNT = 1'b0,
      CSR_CLUSTER_BYTES = 1'b1
   } csr_index_type;

   // One table row: the three bytes shared by an even and an odd entry.
   typedef logic [LANES-1:0][BYTE_W-1:0] row_type;

   typedef struct packed {
      logic [ENTRY_W-1:0] value;
      logic               free;
   } entry_status_type;

endpackage

FILE: design/fat12_cluster_table_engine_top.sv
// ----------------------------------------------------------------------------
// FAT12 cluster table engine
// Packed FAT12 allocation table with byte, entry, free-search and count
// operations, one request at a time.
// ----------------------------------------------------------------------------
// The table sits in three byte-wide RAM lanes, one row per pair of entries, so
// a whole entry is read in one access. A byte write, and any byte or entry
// access outside the table, goes from decode through the access state to the
// done state, where the result is offered; the other byte and entry operations
// also pass through the lookup state. The free searches and the free count step
// through the entries one per cycle over the single read port and the shared
// entry unit, visiting at most cluster_count entries, clipped to the table; a
// search stops at its hit. The table is not cleared after reset and must be
// loaded before it is read. Configuration may be written at any time the
// engine is idle.
`include "fat12_cluster_table_engine_top_defines.svh"

module fat12_cluster_table_engine_top
   import fat12_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // req_tdata: entry_index[11:0], entry_value[23:12], byte_address[36:24],
   //            byte_value[44:37], zero fill
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // req_tuser: operation[2:0]
   input  logic [OP_W-1:0]        req_tuser,
   // rsp_tdata: entry_result[11:0], free_index[23:12], free_count[35:24],
   //            free_bytes[59:36], byte_result[67:60], zero fill
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   // rsp_tuser: found[0]
   output logic                   rsp_tuser,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_index,
   input  logic [CFG_BYTES_W-1:0] csr_data
);

   localparam int ROWS        = (MAX_ENTRIES + 1) / 2;
   localparam int TABLE_BYTES = ROWS * LANES;
   localparam int ROW_W       = $clog2(ROWS);
   localparam int ENTRY_IDX_W = $clog2(MAX_ENTRIES);
   localparam int SCAN_W      = $clog2(MAX_ENTRIES + 1);
   localparam int PROD3_W     = ADDR_W + ENTRY_W;
   localparam int PRODB_W     = COUNT_W + CFG_BYTES_W;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_DECODE = 8'b0000_0010,
      ST_ACCESS = 8'b0000_0100,
      ST_LOOKUP = 8'b0000_1000,
      ST_SCAN   = 8'b0001_0000,
      ST_MUL    = 8'b0010_0000,
      ST_SAT    = 8'b0100_0000,
      ST_DONE   = 8'b1000_0000
   } state_type;

   // Control registers
   state_type               state_ff, state_in;
   logic [SCAN_W-1:0]       issue_idx_ff, issue_idx_in;
   logic                    pipe_valid_ff, pipe_valid_in;
   logic                    seen_ff, seen_in;
   logic [COUNT_W-1:0]      cnt_ff, cnt_in;
   logic                    rsp_tvalid_ff, rsp_tvalid_in;
   logic [COUNT_W-1:0]      cluster_count_ff, cluster_count_in;
   logic [CFG_BYTES_W-1:0]  cluster_bytes_ff, cluster_bytes_in;

   // Payload registers
   op_type                  op_ff, op_in;
   logic [ENTRY_W-1:0]      entry_index_ff, entry_index_in;
   logic [ENTRY_W-1:0]      entry_value_ff, entry_value_in;
   logic [ADDR_W-1:0]       byte_address_ff, byte_address_in;
   logic [BYTE_W-1:0]       byte_value_ff, byte_value_in;
   logic [ROW_W-1:0]        row_ff, row_in;
   logic                    in_range_ff, in_range_in;
   logic [LANE_W-1:0]       lane_ff, lane_in;
   logic                    odd_ff, odd_in;
   logic [SCAN_W-1:0]       end_ff, end_in;
   logic                    pipe_odd_ff, pipe_odd_in;
   logic [ENTRY_IDX_W-1:0]  pipe_idx_ff, pipe_idx_in;
   logic [PRODB_W-1:0]      prod_ff, prod_in;
   logic [ENTRY_W-1:0]      res_entry_ff, res_entry_in;
   logic [ENTRY_W-1:0]      res_free_index_ff, res_free_index_in;
   logic                    res_found_ff, res_found_in;
   logic [COUNT_W-1:0]      res_count_ff, res_count_in;
   logic [BYTES_W-1:0]      res_bytes_ff, res_bytes_in;
   logic [BYTE_W-1:0]       res_byte_ff, res_byte_in;
   logic [RSP_DATA_W-1:0]   rsp_tdata_ff, rsp_tdata_in;
   logic                    rsp_found_ff, rsp_found_in;

   // Datapath
   logic                    req_transfer;
   logic [PROD3_W-1:0]      byte_prod;
   logic [ROW_W-1:0]        byte_row;
   logic [ADDR_W-1:0]       row_times3;
   logic [ADDR_W-1:0]       lane_diff;
   logic [LANE_W-1:0]       lane_comb;
   logic [ADDR_W:0]         end_raw;
   logic                    issue_ok;
   logic                    hit;
   logic                    out_free;
   logic                    ram_rd_en;
   logic [ROW_W-1:0]        ram_rd_addr;
   logic [LANES-1:0]        lane_wr_en;
   row_type                 wr_row;
   row_type                 rd_row;
   logic                    eu_odd;
   logic [ENTRY_W-1:0]      eu_new_value;
   entry_status_type        eu_status;
   row_type                 eu_merged;

   assign req_tready   = (state_ff == ST_IDLE);
   assign req_transfer = req_tvalid && req_tready;
   assign csr_ready    = 1'b1;
   assign rsp_tvalid   = rsp_tvalid_ff;
   assign rsp_tdata    = rsp_tdata_ff;
   assign rsp_tuser    = rsp_found_ff;
   assign out_free     = !rsp_tvalid_ff || rsp_tready;

   // Byte address to row and lane: reciprocal multiply, then a remainder.
   assign byte_prod  = PROD3_W'(byte_address_ff) * PROD3_W'(RECIP3);
   assign byte_row   = ROW_W'(byte_prod >> RECIP3_SHIFT);
   assign row_times3 = (ADDR_W'(row_ff) << 1) + ADDR_W'(row_ff);
   assign lane_diff  = byte_address_ff - row_times3;
   assign lane_comb  = lane_diff[LANE_W-1:0];

   assign end_raw      = (ADDR_W + 1)'(cluster_count_ff) + (ADDR_W + 1)'(2);
   assign issue_ok     = (issue_idx_ff < end_ff);
   assign hit          = pipe_valid_ff && eu_status.free;
   assign eu_odd       = (state_ff == ST_SCAN) ? pipe_odd_ff : odd_ff;
   assign eu_new_value = (op_ff == OP_CLEAR_ENTRY) ? '0 : entry_value_ff;

   fat12_entry_unit u_entry_unit (
      .row       (rd_row),
      .odd       (eu_odd),
      .new_value (eu_new_value),
      .status    (eu_status),
      .merged    (eu_merged)
   );

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      fat12_ram #(
         .WIDTH (BYTE_W),
         .DEPTH (ROWS)
      ) u_ram (
         .clock   (clock),
         .wr_en   (lane_wr_en[g]),
         .wr_addr (row_ff),
         .wr_data (wr_row[g]),
         .rd_en   (ram_rd_en),
         .rd_addr (ram_rd_addr),
         .rd_data (rd_row[g])
      );
   end

   always_comb begin
      state_in          = state_ff;
      issue_idx_in      = issue_idx_ff;
      pipe_valid_in     = 1'b0;
      seen_in           = seen_ff;
      cnt_in            = cnt_ff;
      rsp_tvalid_in     = rsp_tvalid_ff && !rsp_tready;
      cluster_count_in  = cluster_count_ff;
      cluster_bytes_in  = cluster_bytes_ff;
      op_in             = op_ff;
      entry_index_in    = entry_index_ff;
      entry_value_in    = entry_value_ff;
      byte_address_in   = byte_address_ff;
      byte_value_in     = byte_value_ff;
      row_in            = row_ff;
      in_range_in       = in_range_ff;
      lane_in           = lane_ff;
      odd_in            = odd_ff;
      end_in            = end_ff;
      pipe_odd_in       = pipe_odd_ff;
      pipe_idx_in       = pipe_idx_ff;
      prod_in           = prod_ff;
      res_entry_in      = res_entry_ff;
      res_free_index_in = res_free_index_ff;
      res_found_in      = res_found_ff;
      res_count_in      = res_count_ff;
      res_bytes_in      = res_bytes_ff;
      res_byte_in       = res_byte_ff;
      rsp_tdata_in      = rsp_tdata_ff;
      rsp_found_in      = rsp_found_ff;
      ram_rd_en         = 1'b0;
      ram_rd_addr       = row_ff;
      lane_wr_en        = '0;
      wr_row            = eu_merged;

      if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_CLUSTER_COUNT: cluster_count_in = csr_data[COUNT_W-1:0];
            CSR_CLUSTER_BYTES: cluster_bytes_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_transfer) begin
               op_in             = op_type'(req_tuser);
               entry_index_in    = req_tdata[11:0];
               entry_value_in    = req_tdata[23:12];
               byte_address_in   = req_tdata[36:24];
               byte_value_in     = req_tdata[44:37];
               res_entry_in      = '0;
               res_free_index_in = '0;
               res_found_in      = 1'b0;
               res_count_in      = '0;
               res_bytes_in      = '0;
               res_byte_in       = '0;
               state_in          = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (op_ff)
               OP_READ_BYTE, OP_WRITE_BYTE: begin
                  row_in      = byte_row;
                  in_range_in = ({1'b0, byte_address_ff} < (ADDR_W + 1)'(TABLE_BYTES));
                  state_in    = ST_ACCESS;
               end
               OP_READ_ENTRY, OP_WRITE_ENTRY, OP_CLEAR_ENTRY: begin
                  row_in      = ROW_W'(entry_index_ff >> 1);
                  odd_in      = entry_index_ff[0];
                  in_range_in = ({1'b0, entry_index_ff} < (ENTRY_W + 1)'(MAX_ENTRIES));
                  state_in    = ST_ACCESS;
               end
               default: begin
                  // Scans cover clusters 2 up to 1 + cluster_count, clipped to the table.
                  if (end_raw > (ADDR_W + 1)'(MAX_ENTRIES)) begin
                     end_in = SCAN_W'(MAX_ENTRIES);
                  end else begin
                     end_in = SCAN_W'(end_raw);
                  end
                  issue_idx_in = SCAN_W'(2);
                  seen_in      = 1'b0;
                  cnt_in       = '0;
                  state_in     = ST_SCAN;
               end
            endcase
         end
         ST_ACCESS: begin
            lane_in = lane_comb;
            if (!in_range_ff) begin
               state_in = ST_DONE;
            end else if (op_ff == OP_WRITE_BYTE) begin
               wr_row                = row_type'({LANES{byte_value_ff}});
               lane_wr_en[lane_comb] = 1'b1;
               state_in              = ST_DONE;
            end else begin
               ram_rd_en = 1'b1;
               state_in  = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            case (op_ff)
               OP_READ_BYTE:  res_byte_in  = rd_row[lane_ff];
               OP_READ_ENTRY: res_entry_in = eu_status.value;
               OP_WRITE_ENTRY: lane_wr_en  = '1;
               OP_CLEAR_ENTRY: begin
                  res_entry_in = eu_status.value;
                  lane_wr_en   = '1;
               end
               default: ;
            endcase
            state_in = ST_DONE;
         end
         ST_SCAN: begin
            // Reads are issued one entry ahead of the check of the returned row.
            ram_rd_addr   = ROW_W'(issue_idx_ff >> 1);
            ram_rd_en     = issue_ok;
            pipe_valid_in = issue_ok;
            pipe_odd_in   = issue_idx_ff[0];
            pipe_idx_in   = ENTRY_IDX_W'(issue_idx_ff);
            if (issue_ok) begin
               issue_idx_in = issue_idx_ff + SCAN_W'(1);
            end
            if (op_ff == OP_COUNT_FREE) begin
               if (hit) begin
                  cnt_in = cnt_ff + COUNT_W'(1);
               end
               if (!issue_ok && !pipe_valid_ff) begin
                  state_in = ST_MUL;
               end
            end else begin
               if (hit && (op_ff == OP_FIRST_FREE || seen_ff)) begin
                  res_found_in      = 1'b1;
                  res_free_index_in = ENTRY_W'(pipe_idx_ff);
                  pipe_valid_in     = 1'b0;
                  state_in          = ST_DONE;
               end else begin
                  if (hit) begin
                     seen_in = 1'b1;
                  end
                  if (!issue_ok && !pipe_valid_ff) begin
                     state_in = ST_DONE;
                  end
               end
            end
         end
         ST_MUL: begin
            prod_in  = PRODB_W'(cnt_ff) * PRODB_W'(cluster_bytes_ff);
            state_in = ST_SAT;
         end
         ST_SAT: begin
            res_count_in = cnt_ff;
            if (prod_ff > PRODB_W'(BYTES_MAX)) begin
               res_bytes_in = BYTES_MAX;
            end else begin
               res_bytes_in = BYTES_W'(prod_ff);
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {4'h0, res_byte_ff, res_bytes_ff, res_count_ff,
                                res_free_index_ff, res_entry_ff};
               rsp_found_in  = res_found_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         issue_idx_ff     <= '0;
         pipe_valid_ff    <= 1'b0;
         seen_ff          <= 1'b0;
         cnt_ff           <= '0;
         rsp_tvalid_ff    <= 1'b0;
         cluster_count_ff <= CLUSTER_COUNT_RESET;
         cluster_bytes_ff <= CLUSTER_BYTES_RESET;
      end else begin
         state_ff         <= state_in;
         issue_idx_ff     <= issue_idx_in;
         pipe_valid_ff    <= pipe_valid_in;
         seen_ff          <= seen_in;
         cnt_ff           <= cnt_in;
         rsp_tvalid_ff    <= rsp_tvalid_in;
         cluster_count_ff <= cluster_count_in;
         cluster_bytes_ff <= cluster_bytes_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff             <= op_in;
      entry_index_ff    <= entry_index_in;
      entry_value_ff    <= entry_value_in;
      byte_address_ff   <= byte_address_in;
      byte_value_ff     <= byte_value_in;
      row_ff            <= row_in;
      in_range_ff       <= in_range_in;
      lane_ff           <= lane_in;
      odd_ff            <= odd_in;
      end_ff            <= end_in;
      pipe_odd_ff       <= pipe_odd_in;
      pipe_idx_ff       <= pipe_idx_in;
      prod_ff           <= prod_in;
      res_entry_ff      <= res_entry_in;
      res_free_index_ff <= res_free_index_in;
      res_found_ff      <= res_found_in;
      res_count_ff      <= res_count_in;
      res_bytes_ff      <= res_bytes_in;
      res_byte_ff       <= res_byte_in;
      rsp_tdata_ff      <= rsp_tdata_in;
      rsp_found_ff      <= rsp_found_in;
   end

   `FAT12_ASSERT_NEXT(a_done_offers_result, (state_ff == ST_DONE) && out_free, rsp_tvalid_ff && (state_ff == ST_IDLE), "finished result was not offered")
   `FAT12_ASSERT_HOLDS(a_scan_no_write, state_ff == ST_SCAN, lane_wr_en == '0, "table written during a scan")
   `FAT12_ASSERT_HOLDS(a_pipe_only_in_scan, pipe_valid_ff, state_ff == ST_SCAN, "scan read pending outside a scan")
   `FAT12_ASSERT_HOLDS(a_count_bounded, state_ff == ST_SCAN, cnt_ff <= issue_idx_ff, "free count ran ahead of the scan")

endmodule

FILE: design/fat12_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module fat12_ram
   import fat12_pkg::*;
#(
   parameter int WIDTH = BYTE_W,
   parameter int DEPTH = DEFAULT_ROWS
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/fat12_entry_unit.sv
// ----------------------------------------------------------------------------
// FAT12 entry unit
// Unpacks one 12-bit entry from a table row, flags it free, and merges a new
// value back into the row.
// ----------------------------------------------------------------------------
module fat12_entry_unit
   import fat12_pkg::*;
(
   input  row_type             row,
   input  logic                odd,
   input  logic [ENTRY_W-1:0]  new_value,
   output entry_status_type    status,
   output row_type             merged
);

   logic [ENTRY_W-1:0] value;

   always_comb begin
      if (odd) begin
         value = {row[2], row[1][7:4]};
      end else begin
         value = {row[1][3:0], row[0]};
      end
   end

   assign status.value = value;
   assign status.free  = (value == '0);

   // The middle byte is shared: only this entry's nibble is replaced.
   always_comb begin
      merged = row;
      if (odd) begin
         merged[1] = (row[1] & LOW_NIBBLE) | {new_value[3:0], 4'h0};
         merged[2] = new_value[11:4];
      end else begin
         merged[0] = new_value[7:0];
         merged[1] = (row[1] & HIGH_NIBBLE) | {4'h0, new_value[11:8]};
      end
   end

endmodule

FILE: verif/fat12_cluster_table_engine_top_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// FAT12 cluster table engine testbench
// Loads the first rows and the last row of the allocation table byte by byte,
// then drives directed and random byte, entry, free-search and free-count
// requests under several register settings and handshake idling patterns. A
// software copy of the packed table predicts every response, which is checked
// field by field in arrival order.
// ---------------------------------------------------------------------------
module fat12_cluster_table_engine_top_tb;
   import fat12_pkg::*;

   localparam int TABLE_BYTES    = ((MAX_ENTRIES_DEFAULT + 1) / 2) * 3;
   localparam int LAST_ROW       = TABLE_BYTES / 3 - 1;
   localparam int LOADED_ROWS    = 6;
   localparam int LOADED_ENTRIES = LOADED_ROWS * 2;
   localparam int LOADED_BYTES   = LOADED_ROWS * 3;
   // Largest cluster count whose scan stays inside the loaded rows.
   localparam int MAX_SCAN_COUNT = LOADED_ENTRIES - 2;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 16;
   localparam int MAX_REPORTS    = 50;

   typedef struct packed {
      op_type             op;
      logic [ENTRY_W-1:0] entry_index;
      logic [ENTRY_W-1:0] entry_value;
      logic [ADDR_W-1:0]  byte_address;
      logic [BYTE_W-1:0]  byte_value;
   } table_request_type;

   typedef struct packed {
      op_type             op;
      logic [ENTRY_W-1:0] entry_result;
      logic [ENTRY_W-1:0] free_index;
      logic               found;
      logic [COUNT_W-1:0] free_count;
      logic [BYTES_W-1:0] free_bytes;
      logic [BYTE_W-1:0]  byte_result;
   } table_response_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic [OP_W-1:0]        req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic                   csr_index  = 1'b0;
   logic [CFG_BYTES_W-1:0] csr_data   = '0;

   // Shadow of the table and of the registers, updated at each transfer.
   logic [BYTE_W-1:0]      fat_image [TABLE_BYTES];
   logic [COUNT_W-1:0]     cluster_count_cfg = CLUSTER_COUNT_RESET;
   logic [CFG_BYTES_W-1:0] cluster_bytes_cfg = CLUSTER_BYTES_RESET;
   table_response_type     pending_responses [$];

   int unsigned sender_idle_pct    = 0;
   int unsigned receiver_stall_pct = 0;
   int unsigned mismatches         = 0;
   int unsigned requests_sent      = 0;
   int unsigned responses_seen     = 0;
   int unsigned scans_sent         = 0;
   int unsigned csr_writes         = 0;
   int unsigned idle_cycles        = 0;

   fat12_cluster_table_engine_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // An even entry is byte 0 plus the low nibble of byte 1; an odd entry is the
   // high nibble of byte 1 plus byte 2 of the same three-byte row.
   function automatic logic [ENTRY_W-1:0] fat_entry(logic [ENTRY_W-1:0] cluster);
      int pos;
      pos = int'(cluster >> 1) * 3;
      if (cluster[0])
         return {fat_image[pos + 2], fat_image[pos + 1][7:4]};
      return {fat_image[pos + 1][3:0], fat_image[pos]};
   endfunction

   function automatic void fat_store(logic [ENTRY_W-1:0] cluster, logic [ENTRY_W-1:0] value);
      int pos;
      pos = int'(cluster >> 1) * 3;
      if (cluster[0]) begin
         fat_image[pos + 2] = value[11:4];
         fat_image[pos + 1] = {value[3:0], fat_image[pos + 1][3:0]};
      end else begin
         fat_image[pos]     = value[7:0];
         fat_image[pos + 1] = {fat_image[pos + 1][7:4], value[11:8]};
      end
   endfunction

   // Searches and counts cover clusters 2 to 1 + cluster_count, never past the table.
   function automatic int scan_end();
      int limit;
      limit = 2 + int'(cluster_count_cfg);
      return (limit > MAX_ENTRIES_DEFAULT) ? MAX_ENTRIES_DEFAULT : limit;
   endfunction

   function automatic table_response_type apply_request(table_request_type r);
      table_response_type rsp;
      int                 free_seen;
      int                 wanted;
      longint unsigned    space;
      rsp       = '0;
      rsp.op    = r.op;
      free_seen = 0;
      case (r.op)
         OP_READ_BYTE: begin
            if (r.byte_address < TABLE_BYTES)
               rsp.byte_result = fat_image[r.byte_address];
         end
         OP_WRITE_BYTE: begin
            if (r.byte_address < TABLE_BYTES)
               fat_image[r.byte_address] = r.byte_value;
         end
         OP_READ_ENTRY: begin
            rsp.entry_result = fat_entry(r.entry_index);
         end
         OP_WRITE_ENTRY: begin
            fat_store(r.entry_index, r.entry_value);
         end
         OP_CLEAR_ENTRY: begin
            rsp.entry_result = fat_entry(r.entry_index);
            fat_store(r.entry_index, '0);
         end
         OP_FIRST_FREE, OP_SECOND_FREE: begin
            wanted = (r.op == OP_FIRST_FREE) ? 1 : 2;
            for (int i = 2; i < scan_end() && !rsp.found; i++) begin
               if (fat_entry(ENTRY_W'(i)) == '0) begin
                  free_seen++;
                  if (free_seen == wanted) begin
                     rsp.found      = 1'b1;
                     rsp.free_index = ENTRY_W'(i);
                  end
               end
            end
         end
         default: begin
            for (int i = 2; i < scan_end(); i++)
               if (fat_entry(ENTRY_W'(i)) == '0)
                  free_seen++;
            space = longint'(free_seen) * longint'(cluster_bytes_cfg);
            rsp.free_count = COUNT_W'(free_seen);
            rsp.free_bytes = (space > longint'(BYTES_MAX)) ? BYTES_MAX : BYTES_W'(space);
         end
      endcase
      return rsp;
   endfunction

   task automatic report_mismatch(string msg);
      if (mismatches < MAX_REPORTS)
         $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
   endtask

   task automatic compare_field(op_type op, string field, logic [BYTES_W-1:0] want,
                                logic [BYTES_W-1:0] got);
      if (got !== want)
         report_mismatch($sformatf("%s %s expected %0h, got %0h", op.name(), field, want, got));
   endtask

   // Sends one request, with a random gap before it, and predicts its response
   // at the transfer. Valid is left high so that back-to-back requests need no
   // second assignment in the same step.
   task automatic send_request(op_type op, logic [ENTRY_W-1:0] entry_index = '0,
                               logic [ENTRY_W-1:0] entry_value = '0,
                               logic [ADDR_W-1:0] byte_address = '0,
                               logic [BYTE_W-1:0] byte_value = '0);
      table_request_type r;
      r.op           = op;
      r.entry_index  = entry_index;
      r.entry_value  = entry_value;
      r.byte_address = byte_address;
      r.byte_value   = byte_value;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= REQ_DATA_W'({byte_value, byte_address, entry_value, entry_index});
      do @(posedge clock); while (!req_tready);
      pending_responses.push_back(apply_request(r));
      requests_sent++;
      if (op inside {OP_FIRST_FREE, OP_SECOND_FREE, OP_COUNT_FREE})
         scans_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (responses_seen != requests_sent);
   endtask

   task automatic configure(logic [COUNT_W-1:0] count, logic [CFG_BYTES_W-1:0] bytes);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= CSR_CLUSTER_COUNT;
      csr_data  <= CFG_BYTES_W'(count);
      do @(posedge clock); while (!csr_ready);
      cluster_count_cfg = count;
      csr_index <= CSR_CLUSTER_BYTES;
      csr_data  <= bytes;
      do @(posedge clock); while (!csr_ready);
      cluster_bytes_cfg = bytes;
      csr_valid <= 1'b0;
      csr_writes += 2;
   endtask

   // Writes the three bytes of one row. About five entries in eight are free.
   task automatic load_row(int row);
      logic [ENTRY_W-1:0] even_entry;
      logic [ENTRY_W-1:0] odd_entry;
      even_entry = ($urandom_range(7) < 5) ? '0 : ENTRY_W'($urandom_range(1, 4095));
      odd_entry  = ($urandom_range(7) < 5) ? '0 : ENTRY_W'($urandom_range(1, 4095));
      send_request(OP_WRITE_BYTE, '0, '0, ADDR_W'(row * 3), even_entry[7:0]);
      send_request(OP_WRITE_BYTE, '0, '0, ADDR_W'(row * 3 + 1),
                   {odd_entry[3:0], even_entry[11:8]});
      send_request(OP_WRITE_BYTE, '0, '0, ADDR_W'(row * 3 + 2), odd_entry[11:4]);
   endtask

   // The table is undefined after reset. Only the first rows and the last row
   // are loaded, and every later read and scan stays inside them.
   task automatic test_load_image();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      for (int row = 0; row < LOADED_ROWS; row++)
         load_row(row);
      load_row(LAST_ROW);
      wait_drained();
   endtask

   task automatic test_byte_access();
      sender_idle_pct    = 48;
      receiver_stall_pct = 0;
      send_request(OP_READ_BYTE);
      send_request(OP_WRITE_BYTE, '0, '0, ADDR_W'(TABLE_BYTES - 1), '1);
      send_request(OP_READ_BYTE, '0, '0, ADDR_W'(TABLE_BYTES - 1));
      // Addresses past the table read as zero and drop writes.
      send_request(OP_WRITE_BYTE, '0, '0, '1, 8'hA5);
      send_request(OP_READ_BYTE, '0, '0, '1);
      send_request(OP_READ_BYTE, '0, '0, ADDR_W'(TABLE_BYTES));
   endtask

   task automatic test_entry_access();
      sender_idle_pct    = 0;
      receiver_stall_pct = 48;
      send_request(OP_WRITE_ENTRY, '0, '1);
      send_request(OP_READ_ENTRY, 12'd1);
      send_request(OP_WRITE_ENTRY, '1, 12'hABC);
      send_request(OP_READ_ENTRY, 12'hFFE);
      // Clearing one entry of a row must keep its neighbour's nibble.
      send_request(OP_CLEAR_ENTRY, '1);
      send_request(OP_CLEAR_ENTRY, '0);
      send_request(OP_READ_ENTRY, 12'd1);
      send_request(OP_READ_ENTRY, '0);
   endtask

   task automatic test_free_search();
      configure(12'd1, CLUSTER_BYTES_RESET);
      sender_idle_pct    = 20;
      receiver_stall_pct = 20;
      send_request(OP_WRITE_ENTRY, 12'd2, 12'd1);
      send_request(OP_FIRST_FREE);
      send_request(OP_CLEAR_ENTRY, 12'd2);
      send_request(OP_FIRST_FREE);
      send_request(OP_SECOND_FREE);
      send_request(OP_COUNT_FREE);
      // An empty scan range finds nothing and counts nothing.
      configure('0, '0);
      send_request(OP_FIRST_FREE);
      send_request(OP_COUNT_FREE);
      // The widest range is clipped at the end of the table; free entries near
      // its start make the searches stop inside the loaded rows.
      send_request(OP_CLEAR_ENTRY, 12'd4);
      send_request(OP_CLEAR_ENTRY, 12'd5);
      configure('1, '1);
      send_request(OP_FIRST_FREE);
      send_request(OP_SECOND_FREE);
      // The largest cluster size over the whole loaded range.
      configure(COUNT_W'(MAX_SCAN_COUNT), '1);
      send_request(OP_COUNT_FREE);
   endtask

   task automatic run_random_phase(logic [COUNT_W-1:0] count, logic [CFG_BYTES_W-1:0] bytes,
                                   int unsigned idle_pct, int unsigned stall_pct, int items);
      configure(count, bytes);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      // Accesses land on the loaded rows, mostly on the scanned clusters, so that
      // writes and clears keep changing what the searches and counts see.
      repeat (items) begin
         send_request(op_type'($urandom_range(7)),
            ENTRY_W'(($urandom_range(7) == 0) ? 4094 + $urandom_range(1)
                                              : $urandom_range(LOADED_ENTRIES - 1)),
            ENTRY_W'(($urandom_range(2) == 0) ? 0 : $urandom_range(4095)),
            ADDR_W'(($urandom_range(7) == 0) ? $urandom_range(TABLE_BYTES, (1 << ADDR_W) - 1)
                  : ($urandom_range(7) == 0) ? $urandom_range(TABLE_BYTES - 3, TABLE_BYTES - 1)
                                             : $urandom_range(LOADED_BYTES - 1)),
            BYTE_W'($urandom));
      end
      wait_drained();
   endtask

   task automatic test_random_phases();
      run_random_phase(COUNT_W'($urandom_range(2, MAX_SCAN_COUNT)), 13'd512, 0, 0, 16);
      run_random_phase(COUNT_W'(MAX_SCAN_COUNT), '1, 48, 0, 16);
      run_random_phase('0, '0, 0, 48, 16);
      run_random_phase(COUNT_W'($urandom_range(1, MAX_SCAN_COUNT)), 13'd4096, 20, 20, 16);
      run_random_phase(COUNT_W'(MAX_SCAN_COUNT), CFG_BYTES_W'($urandom_range(8191)),
                       48, 0, 14);
      run_random_phase(COUNT_W'($urandom_range(1, MAX_SCAN_COUNT)), CLUSTER_BYTES_RESET,
                       0, 48, 14);
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      table_response_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         responses_seen <= responses_seen + 1;
         if (pending_responses.size() == 0) begin
            report_mismatch($sformatf("response with no request outstanding, tdata %h",
                                      rsp_tdata));
         end else begin
            want = pending_responses.pop_front();
            compare_field(want.op, "entry_result", BYTES_W'(want.entry_result),
                          BYTES_W'(rsp_tdata[11:0]));
            compare_field(want.op, "free_index", BYTES_W'(want.free_index),
                          BYTES_W'(rsp_tdata[23:12]));
            compare_field(want.op, "free_count", BYTES_W'(want.free_count),
                          BYTES_W'(rsp_tdata[35:24]));
            compare_field(want.op, "free_bytes", want.free_bytes, rsp_tdata[59:36]);
            compare_field(want.op, "byte_result", BYTES_W'(want.byte_result),
                          BYTES_W'(rsp_tdata[67:60]));
            compare_field(want.op, "zero fill", '0, BYTES_W'(rsp_tdata[RSP_DATA_W-1:68]));
            compare_field(want.op, "found", BYTES_W'(want.found), BYTES_W'(rsp_tuser));
         end
      end
   end

   // Ends the run when no transfer of any kind has happened for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_load_image();
      test_byte_access();
      test_entry_access();
      test_free_search();
      test_random_phases();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Checked %0d responses to %0d requests, %0d of them free searches or counts.",
               responses_seen, requests_sent, scans_sent);
      $display("Register writes: %0d, from an empty scan range to one clipped at the table end.",
               csr_writes);
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+design
design/fat12_pkg.sv
design/fat12_ram.sv
design/fat12_entry_unit.sv
design/fat12_cluster_table_engine_top.sv
verif/fat12_cluster_table_engine_top_tb.sv
